// ===== src/sapq_pkg.sv =====
`default_nettype none

package sapq_pkg;

    // Queue depth and the widths that follow from it.
    localparam int CAPACITY = 8;
    localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W    = $clog2(CAPACITY + 1);

    // Data and result field widths.
    localparam int DATA_W   = 32;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 4;

    // Operation codes.
    localparam logic FUNC_PUSH = 1'b0;
    localparam logic FUNC_POP  = 1'b1;

    // Result status codes.
    localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_OVERFLOW  = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_UNDERFLOW = 2'd2;

endpackage

`default_nettype wire

// ===== src/sorted_array_priority_queue.sv =====
`default_nettype none

// Priority queue of signed 32-bit values held sorted ascending in a single-port-read,
// single-port-write memory of CAPACITY entries, addressed circularly from a head pointer.
// Each accepted operation (func 0 push, func 1 pop) gives exactly one result transfer with
// pop_value, status (0 ok, 1 overflow, 2 underflow) and entry_count after the operation.
// Items are handled one at a time. A push moves each larger entry up one place before it
// writes the new value; a push to an empty or full queue skips the move. The input stalls
// until the result has been registered, so the next transfer is accepted only after that;
// a stalled result holds the block until the output register frees up. The insertion loop,
// limited by the memory ports, moves one entry per cycle with one read and one write. No
// clearing pass is needed after reset; only entries inside the held range are ever read.
module sorted_array_priority_queue
    import sapq_pkg::*;
(
    input  wire                        clk,
    input  wire                        rst_n,
    input  wire                        in_valid,
    output logic                       in_stall,
    input  wire                        func,
    input  wire signed [DATA_W-1:0]    push_value,
    output logic                       out_valid,
    input  wire                        out_stall,
    output logic signed [DATA_W-1:0]   pop_value,
    output logic [STATUS_W-1:0]        status,
    output logic [COUNT_W-1:0]         entry_count
);

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_SHIFT = 5'b00010,
        S_PLACE = 5'b00100,
        S_POP   = 5'b01000,
        S_DONE  = 5'b10000
    } state_t;

    localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

    // Circular address: base + offset, wrapped with one compare and subtract.
    function automatic logic [IDX_W-1:0] slot(input logic [IDX_W-1:0] base,
                                              input logic [IDX_W-1:0] off);
        logic [IDX_W:0] sum;
        sum = {1'b0, base} + {1'b0, off};
        if (sum >= (IDX_W + 1)'(CAPACITY))
        begin
            sum = sum - (IDX_W + 1)'(CAPACITY);
        end
        return sum[IDX_W-1:0];
    endfunction

    state_t                     state_reg, state_next;
    logic [IDX_W-1:0]           head_reg, head_next;
    logic [CNT_W-1:0]           count_reg, count_next;
    logic [IDX_W-1:0]           pos_reg, pos_next;
    logic signed [DATA_W-1:0]   val_reg, val_next;
    logic signed [DATA_W-1:0]   pend_value_reg, pend_value_next;
    logic [STATUS_W-1:0]        pend_status_reg, pend_status_next;
    logic                       out_valid_reg, out_valid_next;
    logic signed [DATA_W-1:0]   out_value_reg;
    logic [STATUS_W-1:0]        out_status_reg;
    logic [COUNT_W-1:0]         out_count_reg;
    logic                       out_load;

    // Memory ports.
    logic signed [DATA_W-1:0]   mem [CAPACITY];
    logic                       rd_en;
    logic [IDX_W-1:0]           rd_addr;
    logic signed [DATA_W-1:0]   rd_data_reg;
    logic                       wr_en;
    logic [IDX_W-1:0]           wr_addr;
    logic signed [DATA_W-1:0]   wr_data;

    logic in_xfer;

    assign in_stall = (state_reg != S_IDLE);
    assign in_xfer  = in_valid && !in_stall;

    // Sequencer. During the shift the read of the next lower entry and the write of the
    // moved entry always address different slots, so no forwarding is needed.
    always_comb
    begin
        state_next       = state_reg;
        head_next        = head_reg;
        count_next       = count_reg;
        pos_next         = pos_reg;
        val_next         = val_reg;
        pend_value_next  = pend_value_reg;
        pend_status_next = pend_status_reg;
        out_load         = 1'b0;
        rd_en            = 1'b0;
        rd_addr          = head_reg;
        wr_en            = 1'b0;
        wr_addr          = head_reg;
        wr_data          = val_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (in_xfer)
                begin
                    pend_value_next  = '0;
                    pend_status_next = STATUS_OK;
                    if (func == FUNC_PUSH)
                    begin
                        val_next = push_value;
                        if (count_reg == CAP_CNT)
                        begin
                            pend_status_next = STATUS_OVERFLOW;
                            state_next       = S_DONE;
                        end
                        else if (count_reg == '0)
                        begin
                            wr_en      = 1'b1;
                            wr_addr    = head_reg;
                            wr_data    = push_value;
                            count_next = count_reg + CNT_W'(1);
                            state_next = S_DONE;
                        end
                        else
                        begin
                            pos_next   = IDX_W'(count_reg);
                            rd_en      = 1'b1;
                            rd_addr    = slot(head_reg, IDX_W'(count_reg) - IDX_W'(1));
                            state_next = S_SHIFT;
                        end
                    end
                    else
                    begin
                        if (count_reg == '0)
                        begin
                            pend_status_next = STATUS_UNDERFLOW;
                            state_next       = S_DONE;
                        end
                        else
                        begin
                            rd_en      = 1'b1;
                            rd_addr    = head_reg;
                            state_next = S_POP;
                        end
                    end
                end
            end

            S_SHIFT:
            begin
                wr_en   = 1'b1;
                wr_addr = slot(head_reg, pos_reg);
                if (rd_data_reg > val_reg)
                begin
                    // Move the larger entry up one place and look one lower.
                    wr_data  = rd_data_reg;
                    pos_next = pos_reg - IDX_W'(1);
                    if (pos_reg == IDX_W'(1))
                    begin
                        state_next = S_PLACE;
                    end
                    else
                    begin
                        rd_en   = 1'b1;
                        rd_addr = slot(head_reg, pos_reg - IDX_W'(2));
                    end
                end
                else
                begin
                    wr_data    = val_reg;
                    count_next = count_reg + CNT_W'(1);
                    state_next = S_DONE;
                end
            end

            S_PLACE:
            begin
                // New value is the smallest: it goes to the head.
                wr_en      = 1'b1;
                wr_addr    = slot(head_reg, pos_reg);
                wr_data    = val_reg;
                count_next = count_reg + CNT_W'(1);
                state_next = S_DONE;
            end

            S_POP:
            begin
                pend_value_next = rd_data_reg;
                count_next      = count_reg - CNT_W'(1);
                if (count_reg == CNT_W'(1))
                begin
                    head_next = '0;
                end
                else
                begin
                    head_next = slot(head_reg, IDX_W'(1));
                end
                state_next = S_DONE;
            end

            S_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_load   = 1'b1;
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Output register valid flag.
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            head_reg      <= '0;
            count_reg     <= '0;
            pos_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            count_reg     <= count_next;
            pos_reg       <= pos_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        val_reg         <= val_next;
        pend_value_reg  <= pend_value_next;
        pend_status_reg <= pend_status_next;
        if (out_load)
        begin
            out_value_reg  <= pend_value_reg;
            out_status_reg <= pend_status_reg;
            out_count_reg  <= COUNT_W'(count_reg);
        end
    end

    // Store: one write port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Store: one read port with registered data.
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign out_valid   = out_valid_reg;
    assign pop_value   = out_value_reg;
    assign status      = out_status_reg;
    assign entry_count = out_count_reg;

    // The fill level never passes the capacity.
    assert property (@(posedge clk) disable iff (!rst_n) count_reg <= CAP_CNT)
        else $error("entry count above capacity");

    // An empty queue always has its head at slot zero.
    assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == '0) |-> (head_reg == '0))
        else $error("empty queue with nonzero head");

    // A staged overflow result only comes from a full queue.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DONE && pend_status_reg == STATUS_OVERFLOW) |-> (count_reg == CAP_CNT))
        else $error("overflow reported on a queue that is not full");

    // A new result appears only out of the finishing state.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == S_DONE))
        else $error("result raised outside the finishing state");

    // Every pop read returns through the pop state in the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_xfer && func == FUNC_POP && count_reg != '0) |=> (state_reg == S_POP))
        else $error("pop read not followed by pop state");

endmodule

`default_nettype wire
